[rtl/longest_increasing_run_tracker_unit_assert.svh]
// assertion macros for the tracker top level
`ifndef LONGEST_INCREASING_RUN_TRACKER_UNIT_ASSERT_SVH
`define LONGEST_INCREASING_RUN_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LIRT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define LIRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

[rtl/lirt_pkg.sv]
package lirt_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_BITS        = 32;
    localparam int RUN_BITS       = 11;
    localparam int OUT_DATA_BITS  = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic rd_top;
        logic rd_mid;
        logic init_search;
        logic cmp_step;
        logic append;
        logic set_ovf;
        logic write_lo;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic full;
        logic rd_less;
        logic range_done;
        logic out_free;
    } sts_t;

endpackage

[rtl/lirt_ram.sv]
module lirt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lirt_ctrl.sv]
module lirt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lirt_pkg::sts_t  sts,
    output lirt_pkg::cmd_t  cmd
);

    lirt_pkg::state_t state_reg;
    lirt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lirt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lirt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    cmd.rd_top = !sts.count_zero;
                    state_next = lirt_pkg::ST_CHECK;
                end
            end
            lirt_pkg::ST_CHECK:
            begin
                if (sts.count_zero || sts.rd_less)
                begin
                    // greater than every tail: grow the store, or flag overflow when full
                    cmd.append  = !sts.full;
                    cmd.set_ovf = sts.full;
                    state_next  = lirt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.init_search = 1'b1;
                    state_next      = lirt_pkg::ST_SRCH_RD;
                end
            end
            lirt_pkg::ST_SRCH_RD:
            begin
                if (sts.range_done)
                begin
                    cmd.write_lo = 1'b1;
                    state_next   = lirt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = lirt_pkg::ST_SRCH_CMP;
                end
            end
            lirt_pkg::ST_SRCH_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = lirt_pkg::ST_SRCH_RD;
            end
            lirt_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = lirt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lirt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lirt_dp.sv]
module lirt_dp #(
    parameter int DEPTH      = lirt_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = lirt_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [lirt_pkg::IN_BITS-1:0] in_value,
    input  logic                                in_last,
    input  lirt_pkg::cmd_t                      cmd,
    output lirt_pkg::sts_t                      sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lirt_pkg::RUN_BITS-1:0]       out_run_length,
    output logic                                out_overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VALUE_BITS-1:0]     value_reg;
    logic                             last_reg;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic                             ovf_reg;
    logic                             ovf_next;
    logic [AW-1:0]                    lo_reg;
    logic [AW-1:0]                    lo_next;
    logic [AW-1:0]                    hi_reg;
    logic [AW-1:0]                    hi_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [lirt_pkg::RUN_BITS-1:0]    run_length_reg;
    logic                             overflow_reg;

    logic [CW-1:0]                    top_full;
    logic [AW-1:0]                    top_idx;
    logic [AW-1:0]                    mid;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic [VALUE_BITS-1:0]            rd_data;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;

    assign top_full = count_reg - CW'(1);
    assign top_idx  = top_full[AW-1:0];
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign rd_en   = cmd.rd_top | cmd.rd_mid;
    assign rd_addr = cmd.rd_top ? top_idx : mid;
    assign wr_en   = cmd.append | cmd.write_lo;
    assign wr_addr = cmd.append ? count_reg[AW-1:0] : lo_reg;

    lirt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_tails (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(DEPTH));
    assign sts.rd_less    = ($signed(rd_data) < value_reg);
    assign sts.range_done = (lo_reg == hi_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.init_search)
        begin
            lo_next = '0;
            hi_next = top_idx;
        end
        if (cmd.cmp_step)
        begin
            if (sts.rd_less)
            begin
                lo_next = mid + AW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.start)
        begin
            value_reg <= VALUE_BITS'(in_value);
            last_reg  <= in_last;
        end
        if (cmd.emit)
        begin
            run_length_reg <= lirt_pkg::RUN_BITS'(count_reg);
            overflow_reg   <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_run_length = run_length_reg;
    assign out_overflow   = overflow_reg;

endmodule

[rtl/longest_increasing_run_tracker_unit.sv]
// longest strictly increasing run tracker: each item carries one signed value of
// a sequence and gets back one result, the length of the longest strictly
// increasing subsequence seen so far (patience method) plus a sticky overflow
// flag. tails live in a single-port-write, registered-read ram searched by a
// binary search; every search step passes through a ram read state and a
// compare state. items are taken one at a time; the next item is accepted
// as soon as the result is parked in the output register. an item with
// tlast set ends the sequence: its own result is reported, then the length
// and overflow flag clear. once the store holds DEPTH tails, a larger value
// is dropped and the overflow flag sets. no clearing pass is needed after
// reset, only tails below the current count are ever read.
module longest_increasing_run_tracker_unit #(
    parameter int DEPTH      = lirt_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = lirt_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [lirt_pkg::IN_BITS-1:0]           s_tdata,   // [31:0] value (signed)
    input  logic                                   s_tlast,   // last item of the sequence
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [lirt_pkg::OUT_DATA_BITS-1:0]     m_tdata    // [10:0] run_length,
                                                              // [11] overflow, [15:12] zero
);

    lirt_pkg::cmd_t                 dp_cmd;
    lirt_pkg::sts_t                 dp_sts;
    logic [lirt_pkg::RUN_BITS-1:0]  run_length;
    logic                           overflow;

    // sequencing: accept, top-of-store check, search steps, result hand-off
    lirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // tails ram, length counter, search bounds and output register
    lirt_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_value       ($signed(s_tdata)),
        .in_last        (s_tlast),
        .cmd            (dp_cmd),
        .sts            (dp_sts),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_run_length (run_length),
        .out_overflow   (overflow)
    );

    assign m_tdata = {{(lirt_pkg::OUT_DATA_BITS - lirt_pkg::RUN_BITS - 1){1'b0}},
                      overflow, run_length};

`include "longest_increasing_run_tracker_unit_assert.svh"

    // never grow a full store
    `LIRT_ASSERT_IMPL(a_no_append_full, dp_cmd.append, !dp_sts.full)
    // a result may only be loaded when the output register is free
    `LIRT_ASSERT_IMPL(a_emit_free, dp_cmd.emit, dp_sts.out_free)
    // one item at a time: acceptance closes the input for the next cycle
    `LIRT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // overflow can only be reported with a full-length run
    `LIRT_ASSERT_IMPL(a_ovf_full, m_tvalid && overflow,
                      run_length == lirt_pkg::RUN_BITS'(DEPTH))

endmodule

[bench/longest_increasing_run_tracker_unit_test.sv]
`timescale 1ns / 100ps

module longest_increasing_run_tracker_unit_test;

    localparam int TRACK_DEPTH  = lirt_pkg::DEPTH_DEF;
    localparam int RUN_W        = lirt_pkg::RUN_BITS;
    localparam int OUT_W        = lirt_pkg::OUT_DATA_BITS;
    localparam int DIR_ROWS     = 19;
    localparam int RANDOM_ITEMS = 1250;
    localparam int FILL_SEQ_IDX = 12;

    // what one result item carries
    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             overflow;
    } run_result_t;

    // one row of the directed table; known rows carry a hand-typed answer
    typedef struct {
        logic [31:0]      value;
        bit               last;
        bit               known;
        logic [RUN_W-1:0] run_length;
        bit               overflow;
    } dir_row_t;

    // kinds of random sequences
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_RISE,
        SHAPE_FALL,
        SHAPE_NARROW,
        SHAPE_EDGES,
        SHAPE_WANDER
    } seq_shape_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;    // [31:0] value (signed)
    logic              s_tlast  = 1'b0;  // last item of the sequence
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // [10:0] run_length, [11] overflow, [15:12] zero

    // predictor state: smallest tail per subsequence length
    logic signed [31:0] tail_store [TRACK_DEPTH];
    int                 tail_count   = 0;
    bit                 seq_overflow = 1'b0;

    // answers owed by the block, oldest first
    run_result_t owed_lengths [$];

    // no idling on either side while set
    bit calm = 1'b0;

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int ovf_results   = 0;
    int longest_seen  = 0;
    int sequences     = 0;
    int random_items  = 0;

    dir_row_t steps [DIR_ROWS] = '{
        // extremes of the value field and equal values
        '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},   // minimum starts a run
        '{32'h7fff_ffff, 1'b0, 1'b1, 11'd2, 1'b0},   // maximum appends
        '{32'h7fff_ffff, 1'b0, 1'b1, 11'd2, 1'b0},   // equal tail replaced, no growth
        '{32'h8000_0000, 1'b0, 1'b1, 11'd2, 1'b0},   // equal minimum
        '{32'h0000_0000, 1'b0, 1'b1, 11'd2, 1'b0},   // zero replaces the maximum
        '{32'h0000_0001, 1'b0, 1'b1, 11'd3, 1'b0},
        '{32'hffff_ffff, 1'b1, 1'b1, 11'd3, 1'b0},   // last item keeps its own length
        '{32'h0000_0005, 1'b1, 1'b1, 11'd1, 1'b0},   // one-item sequence after a clear
        // strictly falling, then a repeat
        '{32'h0000_0003, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0002, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
        // mid-store replacement, left to the predictor
        '{32'h0000_000a, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0014, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_000f, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0010, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'haaaa_aaaa, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h5555_5555, 1'b1, 1'b0, 11'd0, 1'b0}
    };

    longest_increasing_run_tracker_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // patience step: append above the top tail, else replace the first tail not below
    function automatic run_result_t track_value(input logic signed [31:0] v,
                                                input bit last_item);
        int          lo;
        int          hi;
        int          mid;
        run_result_t r;
        if (tail_count == 0 || tail_store[tail_count-1] < v)
        begin
            if (tail_count < TRACK_DEPTH)
            begin
                tail_store[tail_count] = v;
                tail_count++;
            end
            else
                seq_overflow = 1'b1;   // store full, append dropped
        end
        else
        begin
            lo = 0;
            hi = tail_count;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tail_store[mid] < v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < tail_count)
                tail_store[lo] = v;
        end
        r.run_length = RUN_W'(tail_count);
        r.overflow   = seq_overflow;
        if (last_item)
        begin
            tail_count   = 0;
            seq_overflow = 1'b0;
        end
        return r;
    endfunction

    // offer one item, wait for the handshake, then book its answer
    task automatic send_item(input logic [31:0] value, input bit last_item,
                             input bit known, input run_result_t known_res);
        run_result_t predicted;
        while (!calm && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last_item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = track_value(value, last_item);
        if (known)
            predicted = known_res;
        owed_lengths = {owed_lengths, predicted};
        items_sent++;
    endtask

    // hold off the sender until every owed answer is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (owed_lengths.size() != 0)
            @(posedge clk);
    endtask

    // one random sequence of the given shape, closed by a last item
    task automatic send_sequence(input seq_shape_t shape, input int len);
        longint      cur;
        logic [31:0] v;
        logic [31:0] edge_vals [7];
        int          i;
        edge_vals = '{32'h8000_0000, 32'h8000_0001, 32'hffff_ffff, 32'h0000_0000,
                      32'h0000_0001, 32'h7fff_fffe, 32'h7fff_ffff};
        cur = longint'(int'($urandom));
        for (i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_NOISE:  v = $urandom;
                SHAPE_RISE:
                begin
                    // a zero step gives an equal value, which must not grow the run
                    cur += $urandom_range(0, 50);
                    if (cur > 64'sd2147483647)
                        cur = 64'sd2147483647;
                    v = cur[31:0];
                end
                SHAPE_FALL:
                begin
                    cur -= $urandom_range(0, 50);
                    if (cur < -64'sd2147483648)
                        cur = -64'sd2147483648;
                    v = cur[31:0];
                end
                SHAPE_NARROW: v = 32'($urandom_range(0, 15)) - 32'd8;
                SHAPE_EDGES:  v = edge_vals[$urandom_range(0, 6)];
                default:
                begin
                    // mostly rising with dips
                    cur += longint'($urandom_range(0, 60)) - 64'sd20;
                    if (cur > 64'sd2147483647)
                        cur = 64'sd2147483647;
                    if (cur < -64'sd2147483648)
                        cur = -64'sd2147483648;
                    v = cur[31:0];
                end
            endcase
            send_item(v, i == len - 1, 1'b0, '0);
        end
        random_items += len;
        sequences++;
    endtask

    // fill the whole store, push past it, then close near the top of the range
    task automatic send_fill();
        longint cur;
        int     i;
        cur  = -64'sd2147483648 + longint'($urandom_range(0, 1000));
        calm = 1'b1;   // long stretch with no idling on either side
        for (i = 0; i < TRACK_DEPTH + 4; i++)
        begin
            if (i == 300)
                calm = 1'b0;
            cur += $urandom_range(1, 2000);
            send_item(cur[31:0], 1'b0, 1'b0, '0);
        end
        // a smaller value still replaces inside a full store
        send_item(32'(cur - 64'sd5000), 1'b0, 1'b0, '0);
        send_item(32'(cur + 64'sd1), 1'b0, 1'b0, '0);
        send_item(32'h7fff_ffff, 1'b1, 1'b0, '0);
        random_items += TRACK_DEPTH + 7;
        sequences++;
    endtask

    // result side: random stalls, every handshake checked against the oldest answer
    initial
    begin
        run_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tdata[RUN_W] === 1'b1)
                    ovf_results++;
                if (int'(m_tdata[RUN_W-1:0]) > longest_seen)
                    longest_seen = int'(m_tdata[RUN_W-1:0]);
                if (owed_lengths.size() == 0)
                begin
                    $error("result item with nothing owed: m_tdata %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = owed_lengths.pop_front();
                    if (m_tdata[RUN_W-1:0] !== want.run_length)
                    begin
                        $error("run_length: expected %0d, got %0d",
                               want.run_length, m_tdata[RUN_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[RUN_W] !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, m_tdata[RUN_W]);
                        errors++;
                    end
                    if (m_tdata[OUT_W-1:RUN_W+1] !== '0)
                    begin
                        $error("pad bits: expected 0, got %h", m_tdata[OUT_W-1:RUN_W+1]);
                        errors++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int         r;
        int         len;
        seq_shape_t shape;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int k = 0; k < DIR_ROWS; k++)
            send_item(steps[k].value, steps[k].last, steps[k].known,
                      run_result_t'({steps[k].run_length, steps[k].overflow}));
        drain_results();

        // random sequences, one of them fills the store to overflow
        while (random_items < RANDOM_ITEMS)
        begin
            if (sequences == FILL_SEQ_IDX)
                send_fill();
            r = $urandom_range(0, 9);
            case (r)
                0, 1:    shape = SHAPE_NOISE;
                2, 3:    shape = SHAPE_RISE;
                4:       shape = SHAPE_FALL;
                5, 6:    shape = SHAPE_NARROW;
                7:       shape = SHAPE_EDGES;
                default: shape = SHAPE_WANDER;
            endcase
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            send_sequence(shape, len);
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (owed_lengths.size() != 0)
            errors++;

        $display("%0d items in %0d sequences, %0d results checked",
                 items_sent, sequences, results_seen);
        $display("longest run reported %0d, %0d results with overflow set",
                 longest_seen, ovf_results);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/lirt_pkg.sv
rtl/lirt_ram.sv
rtl/lirt_ctrl.sv
rtl/lirt_dp.sv
rtl/longest_increasing_run_tracker_unit.sv
bench/longest_increasing_run_tracker_unit_test.sv
